/* rtl/core/periodic_task_dispatcher_macros.svh */
// Assertion macros shared by the periodic task dispatcher RTL.
`ifndef PERIODIC_TASK_DISPATCHER_MACROS_SVH
`define PERIODIC_TASK_DISPATCHER_MACROS_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define PTD_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define PTD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define PTD_ASSERT_SAME(lbl, ante, cons, msg)
`define PTD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* rtl/core/ptd_pkg.sv */
// Package with types and constants of the periodic task dispatcher.
`timescale 1ns / 1ps
`default_nettype none
package ptd_pkg;

   localparam int MAX_TASKS_DEFAULT = 16;
   localparam int TICK_BITS_DEFAULT = 32;
   localparam int SLOT_STATE_W      = 2;

   typedef enum logic [2:0] {
      CMD_TICK      = 3'd0,
      CMD_ADD       = 3'd1,
      CMD_DELAY     = 3'd2,
      CMD_DELAY_ALL = 3'd3,
      CMD_TERMINATE = 3'd4,
      CMD_REWORK    = 3'd5,
      CMD_SCHEDULE  = 3'd6
   } cmd_type;

   typedef enum logic [2:0] {
      STATUS_OK       = 3'd0,
      STATUS_ERROR    = 3'd1,
      STATUS_DISPATCH = 3'd2,
      STATUS_FAULT    = 3'd3,
      STATUS_DONE     = 3'd4
   } status_type;

   typedef enum logic [SLOT_STATE_W-1:0] {
      SLOT_READY      = 2'd0,
      SLOT_BLOCKED    = 2'd1,
      SLOT_TERMINATED = 2'd2
   } slot_state_type;

   typedef enum logic [2:0] {
      FSM_IDLE  = 3'd0,
      FSM_START = 3'd1,
      FSM_READ  = 3'd2,
      FSM_EXEC  = 3'd3,
      FSM_RESP  = 3'd4
   } fsm_state_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [3:0]  task_slot;
      logic [31:0] amount;
      logic        has_handler;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  task_id;
      logic [31:0] tick_now;
      logic        last;
   } rsp_type;

endpackage
`default_nettype wire

/* rtl/core/periodic_task_dispatcher.sv */
// Periodic task dispatcher top level: command sequencer over the task table.
// Tick, add, unknown commands, empty-table passes and unallocated-slot errors are answered
// from the start state; delay, terminate and rework of an allocated slot take one table
// read and one write-back. A pass or delay-all walks the allocated slots in order and
// waits at each dispatch or fault result; the next request is taken once the final result
// has been accepted. Reset clears the tick counter, the slot count and the handshake;
// table rows are not.
`timescale 1ns / 1ps
`default_nettype none
`include "periodic_task_dispatcher_macros.svh"
module periodic_task_dispatcher #(
   parameter int MAX_TASKS = ptd_pkg::MAX_TASKS_DEFAULT,
   parameter int TICK_BITS = ptd_pkg::TICK_BITS_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire ptd_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output ptd_pkg::rsp_type      rsp_data
);

   // Slot count needs to hold MAX_TASKS itself; a table address only the slots.
   localparam int CNT_W  = $clog2(MAX_TASKS + 1);
   localparam int ADDR_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   // A table row is {state, handler present, period, due tick}.
   localparam int ROW_W  = 2 * TICK_BITS + ptd_pkg::SLOT_STATE_W + 1;

   ptd_pkg::fsm_state_type state_ff, state_in;
   ptd_pkg::req_type       req_ff, req_in;
   ptd_pkg::rsp_type       rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [TICK_BITS-1:0]   tick_ff, tick_in;
   logic [CNT_W-1:0]       used_ff, used_in;
   logic [ADDR_W-1:0]      idx_ff, idx_in;

   // Table RAM port signals.
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [ROW_W-1:0]  ram_wdata;
   logic              ram_re;
   logic [ADDR_W-1:0] ram_raddr;
   logic [ROW_W-1:0]  ram_rdata;

   // Fields of the row that was read, and of the row to be written.
   logic [1:0]           rd_state, wr_state;
   logic                 rd_hnd, wr_hnd;
   logic [TICK_BITS-1:0] rd_period, wr_period;
   logic [TICK_BITS-1:0] rd_due, wr_due;

   // Shared arithmetic unit.
   logic [TICK_BITS-1:0] alu_op;
   logic [TICK_BITS-1:0] alu_sum;
   logic                 alu_due;

   // Decode helpers.
   logic [TICK_BITS-1:0] amt_tb;
   logic [7:0]           slot_wide;
   logic [7:0]           used_wide;
   logic                 slot_in_range;
   logic                 table_full;
   logic                 table_empty;
   logic [CNT_W-1:0]     idx_next;
   logic                 more_slots;
   logic                 walk_cmd;
   logic                 single_cmd;
   logic                 emit_slot;

   ptd_ram #(
      .WIDTH (ROW_W),
      .DEPTH (MAX_TASKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   ptd_alu #(
      .TICK_BITS (TICK_BITS)
   ) u_alu (
      .tick     (tick_ff),
      .operand  (alu_op),
      .due_tick (rd_due),
      .sum      (alu_sum),
      .is_due   (alu_due)
   );

   assign rd_due    = ram_rdata[TICK_BITS-1:0];
   assign rd_period = ram_rdata[2*TICK_BITS-1:TICK_BITS];
   assign rd_hnd    = ram_rdata[2*TICK_BITS];
   assign rd_state  = ram_rdata[ROW_W-1:2*TICK_BITS+1];
   assign ram_wdata = {wr_state, wr_hnd, wr_period, wr_due};

   // The amount field is taken modulo the tick width.
   assign amt_tb        = req_ff.amount[TICK_BITS-1:0];
   assign slot_wide     = {4'b0000, req_ff.task_slot};
   assign used_wide     = 8'(used_ff);
   assign slot_in_range = slot_wide < used_wide;
   assign table_full    = used_ff == CNT_W'(MAX_TASKS);
   assign table_empty   = used_ff == '0;
   assign idx_next      = CNT_W'(idx_ff) + CNT_W'(1);
   assign more_slots    = idx_next < used_ff;

   assign walk_cmd   = (req_ff.cmd == ptd_pkg::CMD_DELAY_ALL) ||
                       (req_ff.cmd == ptd_pkg::CMD_SCHEDULE);
   assign single_cmd = (req_ff.cmd == ptd_pkg::CMD_DELAY) ||
                       (req_ff.cmd == ptd_pkg::CMD_TERMINATE) ||
                       (req_ff.cmd == ptd_pkg::CMD_REWORK);
   // A due ready slot in a schedule pass gives a dispatch or fault result.
   assign emit_slot  = (req_ff.cmd == ptd_pkg::CMD_SCHEDULE) &&
                       (rd_state == ptd_pkg::SLOT_READY) && alu_due;

   // Next-state logic of the command sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ptd_pkg::FSM_IDLE: begin
            if (req_valid) begin
               state_in = ptd_pkg::FSM_START;
            end
         end
         ptd_pkg::FSM_START: begin
            if ((single_cmd && slot_in_range) || (walk_cmd && !table_empty)) begin
               state_in = ptd_pkg::FSM_READ;
            end else begin
               state_in = ptd_pkg::FSM_RESP;
            end
         end
         ptd_pkg::FSM_READ: begin
            state_in = ptd_pkg::FSM_EXEC;
         end
         ptd_pkg::FSM_EXEC: begin
            if (walk_cmd && !emit_slot && more_slots) begin
               state_in = ptd_pkg::FSM_EXEC;
            end else begin
               state_in = ptd_pkg::FSM_RESP;
            end
         end
         ptd_pkg::FSM_RESP: begin
            if (rsp_ready) begin
               if (rsp_ff.last) begin
                  state_in = ptd_pkg::FSM_IDLE;
               end else if (more_slots) begin
                  state_in = ptd_pkg::FSM_READ;
               end
            end
         end
         default: begin
            state_in = ptd_pkg::FSM_IDLE;
         end
      endcase
   end

   // Datapath and table control for each sequencer state.
   always_comb begin
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      tick_in      = tick_ff;
      used_in      = used_ff;
      idx_in       = idx_ff;
      ram_we       = 1'b0;
      ram_waddr    = idx_ff;
      ram_re       = 1'b0;
      ram_raddr    = idx_ff;
      wr_state     = rd_state;
      wr_hnd       = rd_hnd;
      wr_period    = rd_period;
      wr_due       = rd_due;
      alu_op       = amt_tb;

      case (state_ff)
         ptd_pkg::FSM_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
            end
         end
         ptd_pkg::FSM_START: begin
            rsp_in.tick_now = 32'(tick_ff);
            rsp_in.last     = 1'b1;
            rsp_in.task_id  = 4'd0;
            rsp_in.status   = ptd_pkg::STATUS_OK;
            case (req_ff.cmd)
               ptd_pkg::CMD_TICK: begin
                  tick_in         = alu_sum;
                  rsp_in.tick_now = 32'(alu_sum);
                  rsp_valid_in    = 1'b1;
               end
               ptd_pkg::CMD_ADD: begin
                  rsp_valid_in = 1'b1;
                  if (table_full) begin
                     rsp_in.status = ptd_pkg::STATUS_ERROR;
                  end else begin
                     // A new slot's first due tick is its period itself.
                     ram_we         = 1'b1;
                     ram_waddr      = used_ff[ADDR_W-1:0];
                     wr_state       = ptd_pkg::SLOT_READY;
                     wr_hnd         = req_ff.has_handler;
                     wr_period      = amt_tb;
                     wr_due         = amt_tb;
                     used_in        = used_ff + CNT_W'(1);
                     rsp_in.task_id = 4'(used_ff);
                  end
               end
               ptd_pkg::CMD_DELAY, ptd_pkg::CMD_TERMINATE, ptd_pkg::CMD_REWORK: begin
                  rsp_in.task_id = req_ff.task_slot;
                  if (slot_in_range) begin
                     idx_in = slot_wide[ADDR_W-1:0];
                  end else begin
                     rsp_in.status = ptd_pkg::STATUS_ERROR;
                     rsp_valid_in  = 1'b1;
                  end
               end
               ptd_pkg::CMD_DELAY_ALL, ptd_pkg::CMD_SCHEDULE: begin
                  idx_in = '0;
                  if (table_empty) begin
                     rsp_valid_in = 1'b1;
                     if (req_ff.cmd == ptd_pkg::CMD_SCHEDULE) begin
                        rsp_in.status = ptd_pkg::STATUS_DONE;
                     end
                  end
               end
               default: begin
                  rsp_in.status = ptd_pkg::STATUS_ERROR;
                  rsp_valid_in  = 1'b1;
               end
            endcase
         end
         ptd_pkg::FSM_READ: begin
            ram_re = 1'b1;
         end
         ptd_pkg::FSM_EXEC: begin
            if ((req_ff.cmd == ptd_pkg::CMD_REWORK) ||
                (req_ff.cmd == ptd_pkg::CMD_SCHEDULE)) begin
               alu_op = rd_period;
            end
            rsp_in.tick_now = 32'(tick_ff);
            rsp_in.last     = 1'b1;
            rsp_in.task_id  = req_ff.task_slot;
            rsp_in.status   = ptd_pkg::STATUS_OK;
            case (req_ff.cmd)
               ptd_pkg::CMD_DELAY: begin
                  if (rd_state == ptd_pkg::SLOT_TERMINATED) begin
                     rsp_in.status = ptd_pkg::STATUS_ERROR;
                  end else begin
                     ram_we   = 1'b1;
                     wr_state = ptd_pkg::SLOT_BLOCKED;
                     wr_due   = alu_sum;
                  end
               end
               ptd_pkg::CMD_TERMINATE: begin
                  ram_we   = 1'b1;
                  wr_state = ptd_pkg::SLOT_TERMINATED;
                  wr_due   = '0;
               end
               ptd_pkg::CMD_REWORK: begin
                  ram_we   = 1'b1;
                  wr_state = ptd_pkg::SLOT_READY;
                  wr_due   = alu_sum;
               end
               ptd_pkg::CMD_DELAY_ALL: begin
                  if (rd_state != ptd_pkg::SLOT_TERMINATED) begin
                     ram_we   = 1'b1;
                     wr_state = ptd_pkg::SLOT_BLOCKED;
                     wr_due   = alu_sum;
                  end
               end
               ptd_pkg::CMD_SCHEDULE: begin
                  if (alu_due && ((rd_state == ptd_pkg::SLOT_READY) ||
                                  (rd_state == ptd_pkg::SLOT_BLOCKED))) begin
                     ram_we   = 1'b1;
                     wr_state = ptd_pkg::SLOT_READY;
                     wr_due   = alu_sum;
                  end
               end
               default: begin
                  rsp_in.status = ptd_pkg::STATUS_ERROR;
               end
            endcase
            if (!walk_cmd) begin
               rsp_valid_in = 1'b1;
            end else if (emit_slot) begin
               rsp_in.status  = rd_hnd ? ptd_pkg::STATUS_DISPATCH : ptd_pkg::STATUS_FAULT;
               rsp_in.task_id = 4'(idx_ff);
               rsp_in.last    = 1'b0;
               rsp_valid_in   = 1'b1;
            end else if (more_slots) begin
               // Fetch the next slot while this one is written back.
               idx_in    = idx_next[ADDR_W-1:0];
               ram_re    = 1'b1;
               ram_raddr = idx_next[ADDR_W-1:0];
            end else begin
               rsp_in.task_id = 4'd0;
               if (req_ff.cmd == ptd_pkg::CMD_SCHEDULE) begin
                  rsp_in.status = ptd_pkg::STATUS_DONE;
               end
               rsp_valid_in = 1'b1;
            end
         end
         ptd_pkg::FSM_RESP: begin
            if (rsp_ready) begin
               if (rsp_ff.last) begin
                  rsp_valid_in = 1'b0;
               end else if (more_slots) begin
                  rsp_valid_in = 1'b0;
                  idx_in       = idx_next[ADDR_W-1:0];
               end else begin
                  // The last slot of the pass dispatched; the done result follows.
                  rsp_in.status  = ptd_pkg::STATUS_DONE;
                  rsp_in.task_id = 4'd0;
                  rsp_in.last    = 1'b1;
               end
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ptd_pkg::FSM_IDLE;
         rsp_valid_ff <= 1'b0;
         tick_ff      <= '0;
         used_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         tick_ff      <= tick_in;
         used_ff      <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      idx_ff <= idx_in;
   end

   assign req_ready = state_ff == ptd_pkg::FSM_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A pending result exists only while the sequencer waits in its result state.
   `PTD_ASSERT_SAME(a_rsp_only_in_resp, rsp_valid_ff, state_ff == ptd_pkg::FSM_RESP, "result valid outside result state")
   // The slot count never runs past the table size.
   `PTD_ASSERT_SAME(a_used_bound, 1'b1, used_ff <= CNT_W'(MAX_TASKS), "slot count exceeds table size")
   // Any slot worked on lies within the allocated part of the table.
   `PTD_ASSERT_SAME(a_idx_allocated, state_ff == ptd_pkg::FSM_EXEC, CNT_W'(idx_ff) < used_ff, "slot index beyond allocated slots")
   // An add on a table with room allocates exactly one slot.
   `PTD_ASSERT_NEXT(a_add_grows, (state_ff == ptd_pkg::FSM_START) && (req_ff.cmd == ptd_pkg::CMD_ADD) && !table_full, used_ff == $past(used_ff) + CNT_W'(1), "add did not allocate one slot")

endmodule
`default_nettype wire

/* rtl/core/ptd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ptd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                       clock,
   input  wire logic                                       wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                           wr_data,
   input  wire logic                                       rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* rtl/core/ptd_alu.sv */
// Shared tick arithmetic: re-arm sum and wrap-safe due compare.
`timescale 1ns / 1ps
`default_nettype none
module ptd_alu #(
   parameter int TICK_BITS = 32
) (
   input  wire logic [TICK_BITS-1:0] tick,
   input  wire logic [TICK_BITS-1:0] operand,
   input  wire logic [TICK_BITS-1:0] due_tick,
   output logic      [TICK_BITS-1:0] sum,
   output logic                      is_due
);

   logic [TICK_BITS-1:0] diff;

   assign sum  = tick + operand;
   assign diff = tick - due_tick;
   // Less than half the span behind the tick means the top bit is clear.
   assign is_due = ~diff[TICK_BITS-1];

endmodule
`default_nettype wire
